// ----- design/hsm_pkg.sv -----
// Package for the stepper half-step mover.
// Holds the result type, the reset period and the half-step coil table.
// No dependencies.
`timescale 1ns / 1ps

package hsm_pkg;

  localparam logic [31:0] PERIOD_RESET = 32'd2000;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic [3:0] coils;
    logic       busy;
    logic       done;
  } res_t;

  function automatic logic [3:0] half_step_pattern(input logic [2:0] phase);
    logic [3:0] pat;
    unique case (phase)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ----- design/hsm_seq.sv -----
// Move sequencer: period register, phase, step and interval counters.
// Computes the result of each accepted request and updates state on accept.
// Depends on hsm_pkg.
`timescale 1ns / 1ps

module hsm_seq #(
  parameter int COUNT_BITS  = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              accept,
  input  logic              func,
  input  logic [15:0]       step_count,
  input  logic              reverse,
  output hsm_pkg::res_t     res
);

  logic [PERIOD_BITS-1:0] period;
  logic [2:0]             phase;
  logic [COUNT_BITS-1:0]  steps_left;
  logic [PERIOD_BITS-1:0] interval_count;
  logic                   moving;
  logic                   move_reverse;
  logic [3:0]             coil_pattern;

  logic [2:0]             phase_next;
  logic [COUNT_BITS-1:0]  steps_left_next;
  logic [PERIOD_BITS-1:0] interval_count_next;
  logic                   moving_next;
  logic                   move_reverse_next;
  logic [3:0]             coil_pattern_next;
  logic                   done;

  logic [31:0]            count_wide;
  logic [31:0]            wdata_wide;
  logic [COUNT_BITS-1:0]  count;
  logic [PERIOD_BITS-1:0] period_eff;
  logic [PERIOD_BITS-1:0] interval_inc;
  logic [2:0]             phase_step;

  assign count_wide   = {16'd0, step_count};
  assign wdata_wide   = {16'd0, cfg_wdata};
  assign count        = count_wide[COUNT_BITS-1:0];
  assign period_eff   = (period == '0) ? PERIOD_BITS'(1) : period;
  assign interval_inc = interval_count + PERIOD_BITS'(1);

  always_comb begin
    phase_next          = phase;
    steps_left_next     = steps_left;
    interval_count_next = interval_count;
    moving_next         = moving;
    move_reverse_next   = move_reverse;
    coil_pattern_next   = coil_pattern;
    done                = 1'b0;
    phase_step          = move_reverse ? (phase - 3'd1) : (phase + 3'd1);

    if (func == hsm_pkg::FUNC_START) begin
      if (!moving) begin
        if (count == '0) begin
          coil_pattern_next = 4'h0;
          done              = 1'b1;
        end else begin
          move_reverse_next   = reverse;
          phase_next          = reverse ? (phase - 3'd1) : (phase + 3'd1);
          coil_pattern_next   = hsm_pkg::half_step_pattern(phase_next);
          steps_left_next     = count - COUNT_BITS'(1);
          interval_count_next = '0;
          moving_next         = 1'b1;
        end
      end
    end else if (moving) begin
      interval_count_next = interval_inc;
      if (interval_inc >= period_eff) begin
        interval_count_next = '0;
        if (steps_left != '0) begin
          steps_left_next   = steps_left - COUNT_BITS'(1);
          phase_next        = phase_step;
          coil_pattern_next = hsm_pkg::half_step_pattern(phase_step);
        end else begin
          coil_pattern_next = 4'h0;
          moving_next       = 1'b0;
          done              = 1'b1;
        end
      end
    end
  end

  assign res.coils = coil_pattern_next;
  assign res.busy  = moving_next;
  assign res.done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      period         <= hsm_pkg::PERIOD_RESET[PERIOD_BITS-1:0];
      phase          <= '0;
      steps_left     <= '0;
      interval_count <= '0;
      moving         <= 1'b0;
      move_reverse   <= 1'b0;
      coil_pattern   <= 4'h0;
    end else begin
      if (cfg_we) begin
        period <= wdata_wide[PERIOD_BITS-1:0];
      end
      if (accept) begin
        phase          <= phase_next;
        steps_left     <= steps_left_next;
        interval_count <= interval_count_next;
        moving         <= moving_next;
        move_reverse   <= move_reverse_next;
        coil_pattern   <= coil_pattern_next;
      end
    end
  end

endmodule

// ----- design/hsm_out.sv -----
// Result register for the stepper half-step mover.
// Holds one result until the receiver takes it. Depends on hsm_pkg.
`timescale 1ns / 1ps

module hsm_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  hsm_pkg::res_t res_in,
  output logic          can_load,
  output logic          valid,
  input  logic          ready,
  output hsm_pkg::res_t res_out
);

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- design/stepper_half_step_mover_unit.sv -----
// Usage:
// Input stream s_axis: tuser = func (0 tick, 1 start a move); tdata carries
// step_count and reverse. One request per cycle is taken unless a result is stalled.
// Config: cfg_we/cfg_wdata write the step period in ticks; write only while idle (not enforced).
// Output stream m_axis: one result per input request; tdata carries the coil
// pattern and busy; tlast marks a result that ends a move or a zero-step start.
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle, set by the single result register; the
// state update and table lookup sit between the state and result registers.
// Stall: while m_axis_tready is low and a result waits, s_axis_tready drops
// and state holds; input resumes in the cycle the result is taken.
// Reset (rst, synchronous): coils off, phase 0, idle, period 2000 ticks,
// no result pending.
// Depends on hsm_pkg, hsm_seq, hsm_out.
`timescale 1ns / 1ps

module stepper_half_step_mover_unit #(
  parameter int COUNT_BITS  = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] step_count, [16] reverse, rest zero
  input  logic        s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [3:0] coils, [4] busy_res, rest zero
  output logic        m_axis_tlast   // done_res
);

  logic          accept;
  logic          can_load;
  hsm_pkg::res_t res;
  hsm_pkg::res_t res_q;

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  hsm_seq #(
    .COUNT_BITS (COUNT_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .func      (s_axis_tuser),
    .step_count(s_axis_tdata[15:0]),
    .reverse   (s_axis_tdata[16]),
    .res       (res)
  );

  hsm_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (s_axis_tvalid),
    .res_in  (res),
    .can_load(can_load),
    .valid   (m_axis_tvalid),
    .ready   (m_axis_tready),
    .res_out (res_q)
  );

  assign m_axis_tdata = {3'b000, res_q.busy, res_q.coils};
  assign m_axis_tlast = res_q.done;

endmodule
